[design/assert_macros.svh]
// Assertion helper macros shared by the blitter RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[design/rfb_pkg.sv]
// Shared types and constants of the rectangle fill blitter.
// Used by rfb_scan, rectangle_fill_blitter_unit and the testbench; depends on nothing.
package rfb_pkg;

    // Field widths of the command and response transactions.
    localparam int KIND_W     = 2;
    localparam int START_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int GLYPH_W    = 8;
    localparam int LIMIT_W    = 9;
    // Row and column counters hold start plus size without wrapping.
    localparam int CNT_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_FILL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OUTLINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND  = 2'd2;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0] CANVAS_DIM_RESET = 9'd256;
    localparam logic [GLYPH_W-1:0] BACKGROUND_RESET = 8'd32;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start_row;
        logic [START_W-1:0] start_col;
        logic [SIZE_W-1:0]  rect_height;
        logic [SIZE_W-1:0]  rect_width;
        logic [GLYPH_W-1:0] glyph;
    } cmd_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] cell_value;
        logic               is_read_data;
    } rsp_t;

    // Rectangle handed to the scan sequencer; ends are exclusive.
    typedef struct packed {
        logic [CNT_W-1:0]   r0;
        logic [CNT_W-1:0]   c0;
        logic [CNT_W-1:0]   r_end;
        logic [CNT_W-1:0]   c_end;
        logic [GLYPH_W-1:0] glyph;
        logic               border_only;
    } scan_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scan_stat_t;

endpackage

[design/rfb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Holds the canvas cells; depends on nothing.
module rfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rfb_scan.sv]
// Scan sequencer: walks the clipped rectangle one cell per cycle and drives the RAM write port.
// Depends on rfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rfb_scan #(
    parameter int DIM_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rfb_pkg::scan_cmd_t      cmd,
    input  logic [rfb_pkg::CNT_W-1:0] row_lim,
    input  logic [rfb_pkg::CNT_W-1:0] col_lim,
    output rfb_pkg::scan_stat_t     stat,
    output logic                    wr_en,
    output logic [2*DIM_W-1:0]      wr_addr,
    output logic [rfb_pkg::GLYPH_W-1:0] wr_data
);

    import rfb_pkg::*;

    localparam logic [1:0] SC_IDLE  = 2'd0;
    localparam logic [1:0] SC_SETUP = 2'd1;
    localparam logic [1:0] SC_RUN   = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    scan_cmd_t        cmd_reg;
    logic [CNT_W-1:0] row_stop_reg;
    logic [CNT_W-1:0] col_stop_reg;
    logic [CNT_W-1:0] r_last_reg;
    logic [CNT_W-1:0] c_last_reg;
    logic [CNT_W-1:0] row_cnt_reg;
    logic [CNT_W-1:0] col_cnt_reg;
    logic             done_reg;

    logic [CNT_W-1:0] row_stop_next;
    logic [CNT_W-1:0] col_stop_next;
    logic             empty;
    logic [CNT_W-1:0] row_inc;
    logic [CNT_W-1:0] col_inc;
    logic             last_col;
    logic             last_row;
    logic             on_border;

    // Clip the rectangle ends against the canvas limits.
    assign row_stop_next = (cmd_reg.r_end < row_lim) ? cmd_reg.r_end : row_lim;
    assign col_stop_next = (cmd_reg.c_end < col_lim) ? cmd_reg.c_end : col_lim;
    assign empty = (cmd_reg.r0 >= row_stop_next) || (cmd_reg.c0 >= col_stop_next);

    // Cell stepping and border detection against the unclipped edges.
    assign row_inc   = row_cnt_reg + CNT_W'(1);
    assign col_inc   = col_cnt_reg + CNT_W'(1);
    assign last_col  = (col_inc == col_stop_reg);
    assign last_row  = (row_inc == row_stop_reg);
    assign on_border = (row_cnt_reg == cmd_reg.r0) || (col_cnt_reg == cmd_reg.c0) ||
                       (row_cnt_reg == r_last_reg) || (col_cnt_reg == c_last_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    state_next = SC_SETUP;
                end
            end
            SC_SETUP:
            begin
                state_next = empty ? SC_IDLE : SC_RUN;
            end
            SC_RUN:
            begin
                if (last_col && last_row)
                begin
                    state_next = SC_IDLE;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == SC_SETUP) && empty) ||
                         ((state_reg == SC_RUN) && last_col && last_row);
        end
    end

    // Rectangle and counter registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    cmd_reg <= cmd;
                end
            end
            SC_SETUP:
            begin
                row_stop_reg <= row_stop_next;
                col_stop_reg <= col_stop_next;
                r_last_reg   <= cmd_reg.r_end - CNT_W'(1);
                c_last_reg   <= cmd_reg.c_end - CNT_W'(1);
                row_cnt_reg  <= cmd_reg.r0;
                col_cnt_reg  <= cmd_reg.c0;
            end
            SC_RUN:
            begin
                if (last_col)
                begin
                    col_cnt_reg <= cmd_reg.c0;
                    row_cnt_reg <= row_inc;
                end
                else
                begin
                    col_cnt_reg <= col_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Write port: every cell of a fill, border cells only for an outline.
    assign wr_en   = (state_reg == SC_RUN) && (!cmd_reg.border_only || on_border);
    assign wr_addr = {row_cnt_reg[DIM_W-1:0], col_cnt_reg[DIM_W-1:0]};
    assign wr_data = cmd_reg.glyph;

    assign stat.busy = (state_reg != SC_IDLE);
    assign stat.done = done_reg;

    `ASSERT_PROP(a_wr_in_box, clk, rst_n,
        wr_en |-> (row_cnt_reg < row_stop_reg) && (col_cnt_reg < col_stop_reg),
        "scan wrote a cell outside the clipped rectangle")
    `ASSERT_PROP(a_done_pulse, clk, rst_n, done_reg |=> !done_reg,
        "scan done lasted longer than one cycle")
    `ASSERT_NEVER(a_start_busy, clk, rst_n, start && (state_reg != SC_IDLE),
        "scan started while a rectangle was still in progress")

endmodule

[design/rectangle_fill_blitter_unit.sv]
// Top level of the rectangle fill blitter: command FSM, configuration, canvas RAM, response register.
// Depends on rfb_pkg, rfb_ram, rfb_scan and assert_macros.svh.
//
//  Channel   Signals                               Transaction
//  command   cmd_valid, cmd_ready, cmd             kind, start cell, size, glyph
//  response  rsp_valid, rsp_ready, rsp             cell_value, is_read_data
//  config    cfg_we, cfg_index, cfg_wdata          register write, no handshake
//
// A read passes through the RAM read register, the result register and the response register.
// Fill, outline and clear step through every cell of the clipped bounding box (up to 65536
// at the default size), since the single RAM write port stores one cell per cycle; an outline
// still steps through the interior. One command is processed at a time. Reset sets the
// limits to 256 and the background to 32; canvas contents stay undefined until drawn.
// A finished response waits in its register while the next command is accepted.
`include "assert_macros.svh"

module rectangle_fill_blitter_unit #(
    parameter int MAX_DIM = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  rfb_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output rfb_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import rfb_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * DIM_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RDWAIT = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [LIMIT_W-1:0] rows_reg;
    logic [LIMIT_W-1:0] cols_reg;
    logic [GLYPH_W-1:0] bg_reg;
    logic               rd_hit_reg;
    logic [GLYPH_W-1:0] value_reg;
    logic               is_read_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               accept;
    logic               is_read_cmd;
    logic               slot_free;
    logic [CNT_W-1:0]   row_lim;
    logic [CNT_W-1:0]   col_lim;
    logic [CNT_W-1:0]   rd_row;
    logic [CNT_W-1:0]   rd_col;
    logic               rd_hit;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [GLYPH_W-1:0] rd_data;
    logic               scan_start;
    scan_cmd_t          scan_cmd;
    scan_stat_t         scan_stat;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [GLYPH_W-1:0] wr_data;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CANVAS_DIM_RESET;
            cols_reg <= CANVAS_DIM_RESET;
            bg_reg   <= BACKGROUND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CANVAS_ROWS: rows_reg <= cfg_wdata;
                REG_CANVAS_COLS: cols_reg <= cfg_wdata;
                REG_BACKGROUND:  bg_reg   <= cfg_wdata[GLYPH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective clip limits: the register value, capped at the canvas dimension.
    assign row_lim = (int'(rows_reg) < MAX_DIM) ? CNT_W'(rows_reg) : CNT_W'(MAX_DIM);
    assign col_lim = (int'(cols_reg) < MAX_DIM) ? CNT_W'(cols_reg) : CNT_W'(MAX_DIM);

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign accept      = cmd_valid && cmd_ready;
    assign is_read_cmd = (cmd.kind == KIND_READ);

    // Read path; out-of-range reads answer zero instead of the RAM word.
    assign rd_row  = CNT_W'(cmd.start_row);
    assign rd_col  = CNT_W'(cmd.start_col);
    assign rd_hit  = (rd_row < row_lim) && (rd_col < col_lim);
    assign rd_en   = accept && is_read_cmd;
    assign rd_addr = {rd_row[DIM_W-1:0], rd_col[DIM_W-1:0]};

    // Rectangle for the sequencer; a clear covers the whole clipped canvas.
    always_comb
    begin
        if (cmd.kind == KIND_CLEAR)
        begin
            scan_cmd.r0          = '0;
            scan_cmd.c0          = '0;
            scan_cmd.r_end       = row_lim;
            scan_cmd.c_end       = col_lim;
            scan_cmd.glyph       = bg_reg;
            scan_cmd.border_only = 1'b0;
        end
        else
        begin
            scan_cmd.r0          = CNT_W'(cmd.start_row);
            scan_cmd.c0          = CNT_W'(cmd.start_col);
            scan_cmd.r_end       = CNT_W'(cmd.start_row) + CNT_W'(cmd.rect_height);
            scan_cmd.c_end       = CNT_W'(cmd.start_col) + CNT_W'(cmd.rect_width);
            scan_cmd.glyph       = cmd.glyph;
            scan_cmd.border_only = (cmd.kind == KIND_OUTLINE);
        end
    end

    assign scan_start = accept && !is_read_cmd;

    rfb_scan #(
        .DIM_W (DIM_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .cmd     (scan_cmd),
        .row_lim (row_lim),
        .col_lim (col_lim),
        .stat    (scan_stat),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Canvas storage. Reads are issued only while the sequencer is idle, so a read
    // never overlaps a write of the same cell.
    rfb_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !rsp_valid_reg || rsp_ready;

    // Command sequencing.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_read_cmd ? ST_RDWAIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: FSM and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_RESULT) && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload and response register.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_hit_reg <= rd_hit;
        end
        if (state_reg == ST_RDWAIT)
        begin
            value_reg   <= rd_hit_reg ? rd_data : '0;
            is_read_reg <= 1'b1;
        end
        else if ((state_reg == ST_SCAN) && scan_stat.done)
        begin
            value_reg   <= '0;
            is_read_reg <= 1'b0;
        end
        if ((state_reg == ST_RESULT) && slot_free)
        begin
            rsp_reg.cell_value   <= value_reg;
            rsp_reg.is_read_data <= is_read_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_PROP(a_read_waits, clk, rst_n,
        rd_en |=> (state_reg == ST_RDWAIT) && !scan_stat.busy,
        "read issued while the sequencer was active")
    `ASSERT_PROP(a_done_in_scan, clk, rst_n, scan_stat.done |-> (state_reg == ST_SCAN),
        "sequencer finished outside a draw command")
    `ASSERT_PROP(a_rsp_from_result, clk, rst_n,
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_RESULT),
        "response raised without a finished command")

endmodule

[tb/rfb_checker.sv]
// Scoreboard for the rectangle fill blitter: keeps its own canvas and registers,
// predicts each response and compares it field by field. Depends on rfb_pkg.
module rfb_checker #(
    parameter int MAX_DIM = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  logic                            cmd_ready,
    input  rfb_pkg::cmd_t                   cmd,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  rfb_pkg::rsp_t                   rsp,
    input  logic                            cfg_we,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              rsp_total
);
    timeunit 1ns;
    timeprecision 1ps;
    import rfb_pkg::*;

    // Shadow copy of the canvas and of the configuration registers.
    bit [GLYPH_W-1:0]   canvas_copy [MAX_DIM*MAX_DIM];
    logic [LIMIT_W-1:0] rows_cfg = CANVAS_DIM_RESET;
    logic [LIMIT_W-1:0] cols_cfg = CANVAS_DIM_RESET;
    logic [GLYPH_W-1:0] bg_cfg   = BACKGROUND_RESET;

    // Responses owed by the block, oldest first.
    rsp_t rsp_due_q [$];
    rsp_t oldest_due;
    int   fails = 0;
    int   seen  = 0;

    assign fail_count = fails;
    assign rsp_total  = seen;

    // The usable extent is the register value, but never more than the canvas.
    function automatic int unsigned clip_limit(input int unsigned lim_val);
        return (lim_val < MAX_DIM) ? lim_val : MAX_DIM;
    endfunction

    // Writes a glyph over a rectangle clipped to the usable extent. Border cells
    // are judged on the unclipped rectangle, so a border beyond the edge is lost.
    function automatic void paint_rect(input int unsigned r0, input int unsigned c0,
                                       input int unsigned h, input int unsigned w,
                                       input logic [GLYPH_W-1:0] g, input bit border_only);
        int unsigned rl;
        int unsigned cl;
        int unsigned r_end;
        int unsigned c_end;
        bit          on_border;
        rl    = clip_limit(rows_cfg);
        cl    = clip_limit(cols_cfg);
        r_end = r0 + h;
        c_end = c0 + w;
        if (h == 0 || w == 0)
            return;
        for (int unsigned r = r0; r < r_end && r < rl; r++)
        begin
            for (int unsigned c = c0; c < c_end && c < cl; c++)
            begin
                on_border = (r == r0) || (c == c0) || (r == r_end - 1) || (c == c_end - 1);
                if (!border_only || on_border)
                    canvas_copy[r * MAX_DIM + c] = g;
            end
        end
    endfunction

    // Applies one command to the shadow canvas and returns the response it owes.
    function automatic rsp_t predict_rsp(input cmd_t c);
        rsp_t p;
        p = '0;
        case (c.kind)
            KIND_FILL:
                paint_rect(c.start_row, c.start_col, c.rect_height, c.rect_width,
                           c.glyph, 1'b0);
            KIND_OUTLINE:
                paint_rect(c.start_row, c.start_col, c.rect_height, c.rect_width,
                           c.glyph, 1'b1);
            KIND_READ:
            begin
                if (c.start_row < clip_limit(rows_cfg) && c.start_col < clip_limit(cols_cfg))
                    p.cell_value = canvas_copy[c.start_row * MAX_DIM + c.start_col];
                p.is_read_data = 1'b1;
            end
            default:
                paint_rect(0, 0, MAX_DIM, MAX_DIM, bg_cfg, 1'b0);
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $time, what);
        fails++;
    endtask

    // Watch the configuration port and both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg <= CANVAS_DIM_RESET;
            cols_cfg <= CANVAS_DIM_RESET;
            bg_cfg   <= BACKGROUND_RESET;
            seen     <= 0;
            rsp_due_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CANVAS_ROWS: rows_cfg <= cfg_wdata;
                    REG_CANVAS_COLS: cols_cfg <= cfg_wdata;
                    REG_BACKGROUND:  bg_cfg   <= cfg_wdata[GLYPH_W-1:0];
                    default: ;
                endcase
            end

            // A command transaction is predicted at once, in order of acceptance.
            if (cmd_valid && cmd_ready)
                rsp_due_q.push_back(predict_rsp(cmd));

            // A response transaction is matched against the oldest owed response.
            if (rsp_valid && rsp_ready)
            begin
                seen <= seen + 1;
                if (rsp_due_q.size() == 0)
                begin
                    report_mismatch($sformatf("response %0d arrived with none owed", seen));
                end
                else
                begin
                    oldest_due = rsp_due_q.pop_front();
                    if (rsp.cell_value !== oldest_due.cell_value)
                        report_mismatch($sformatf("response %0d cell_value %h, predicted %h",
                                                  seen, rsp.cell_value,
                                                  oldest_due.cell_value));
                    if (rsp.is_read_data !== oldest_due.is_read_data)
                        report_mismatch($sformatf("response %0d is_read_data %b, predicted %b",
                                                  seen, rsp.is_read_data,
                                                  oldest_due.is_read_data));
                end
            end
        end
    end

endmodule

[tb/tb.sv]
// Top of the rectangle fill blitter testbench: clock, reset, command and configuration
// stimulus, response stalls and the verdict. Depends on rfb_pkg, rfb_checker and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rfb_pkg::*;

    localparam int CANVAS_DIM   = 256;
    localparam int HOLD_AFTER   = 30;
    localparam int HOLD_CYCLES  = 800;
    localparam int IDLE_PAUSE   = 8;
    localparam int TAIL_CYCLES  = 16;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int ITEMS_PER_PHASE = 13;
    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          mismatches;
    int          rsp_seen;
    int          cmds_sent   = 0;
    int          burst_left  = 0;
    int unsigned cur_rows    = CANVAS_DIM;
    int unsigned cur_cols    = CANVAS_DIM;
    bit          hold_done   = 1'b0;

    rectangle_fill_blitter_unit #(
        .MAX_DIM   (CANVAS_DIM)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rfb_checker #(
        .MAX_DIM    (CANVAS_DIM)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (mismatches),
        .rsp_total  (rsp_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned usable(input int unsigned v);
        return (v < CANVAS_DIM) ? v : CANVAS_DIM;
    endfunction

    function automatic cmd_t make_cmd(input logic [KIND_W-1:0] kind,
                                      input int unsigned sr, input int unsigned sc,
                                      input int unsigned h, input int unsigned w,
                                      input int unsigned g);
        cmd_t c;
        c.kind        = kind;
        c.start_row   = START_W'(sr);
        c.start_col   = START_W'(sc);
        c.rect_height = SIZE_W'(h);
        c.rect_width  = SIZE_W'(w);
        c.glyph       = GLYPH_W'(g);
        return c;
    endfunction

    // Mostly inside the usable extent, so reads hit cleared cells and draws land.
    function automatic int unsigned pick_start(input int unsigned lim);
        if (lim > 0 && $urandom_range(0, 9) < 8)
            return $urandom_range(0, lim - 1);
        return $urandom_range(0, 255);
    endfunction

    // Sizes near the extent, the field's corner values, or anything the field holds.
    function automatic int unsigned pick_size(input int unsigned lim);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return 0;
                    1:       return 1;
                    2:       return 255;
                    3:       return 256;
                    default: return 511;
                endcase
            end
            1:       return $urandom_range(0, 511);
            default: return $urandom_range(0, lim + 2);
        endcase
    endfunction

    function automatic cmd_t random_cmd();
        int unsigned rl;
        int unsigned cl;
        int unsigned pick;
        logic [KIND_W-1:0] kind;
        rl   = usable(cur_rows);
        cl   = usable(cur_cols);
        pick = $urandom_range(0, 19);
        if (pick < 7)
            kind = KIND_READ;
        else if (pick < 12)
            kind = KIND_FILL;
        else if (pick < 17)
            kind = KIND_OUTLINE;
        else
            kind = KIND_CLEAR;
        return make_cmd(kind, pick_start(rl), pick_start(cl), pick_size(rl), pick_size(cl),
                        $urandom_range(0, 255));
    endfunction

    // Offers one command transaction; valid stays up across a burst.
    task automatic offer(input cmd_t c);
        int unsigned gap;
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ready);
        cmds_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops offering and waits until every owed response has come back.
    task automatic settle();
        cmd_valid <= 1'b0;
        while (rsp_seen != cmds_sent)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(d);
        @(posedge clk);
    endtask

    // New canvas setting while idle, then a clear so every usable cell is written.
    task automatic start_phase(input int unsigned rows, input int unsigned cols,
                               input int unsigned bg, input bit poke_unused);
        settle();
        write_reg(REG_CANVAS_ROWS, rows);
        write_reg(REG_CANVAS_COLS, cols);
        write_reg(REG_BACKGROUND, bg);
        if (poke_unused)
            write_reg(REG_UNUSED, $urandom_range(0, 511));
        cfg_we   <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
        offer(make_cmd(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom_range(0, 255)));
    endtask

    task automatic random_run(input int n);
        repeat (n) offer(random_cmd());
    endtask

    // Receiver: stretches of steady, sparse or busy readiness, plus one long hold-off
    // while commands keep coming so that the block backs up into its input.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        rsp_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span)
            begin
                @(posedge clk);
                if (!hold_done && rsp_seen >= HOLD_AFTER && cmd_valid)
                begin
                    hold_done = 1'b1;
                    rsp_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0:       rsp_ready <= 1'b1;
                        1:       rsp_ready <= ($urandom_range(0, 1) == 1);
                        2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                        default: rsp_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // Main sequence: reset, directed commands at reset settings, then random phases.
    initial
    begin
        int k;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full canvas at reset values; reads of the far corner and the origin.
        offer(make_cmd(KIND_CLEAR,   0,   0,   0,   0, 8'h00));
        offer(make_cmd(KIND_READ,    0,   0,   0,   0, 8'h00));
        offer(make_cmd(KIND_READ,  255, 255, 511, 511, 8'hFF));
        // Oversized rectangle at the last cell clips down to that one cell.
        offer(make_cmd(KIND_FILL,  255, 255, 256, 256, 8'hFF));
        offer(make_cmd(KIND_READ,  255, 255,   0,   0, 8'h00));
        offer(make_cmd(KIND_READ,  254, 255,   0,   0, 8'h00));
        // Zero height or zero width draws nothing.
        offer(make_cmd(KIND_FILL,   10,  10,   0,   5, 8'h11));
        offer(make_cmd(KIND_OUTLINE, 10, 10,   5,   0, 8'h11));
        offer(make_cmd(KIND_READ,   10,  10,   0,   0, 8'h00));
        // Outline leaves the interior alone.
        offer(make_cmd(KIND_OUTLINE, 100, 100, 5,   7, 8'hAA));
        offer(make_cmd(KIND_READ,  102, 103,   0,   0, 8'h00));
        offer(make_cmd(KIND_READ,  104, 106,   0,   0, 8'h00));
        offer(make_cmd(KIND_OUTLINE, 50,  50,  1,   1, 8'h00));
        offer(make_cmd(KIND_READ,   50,  50,   0,   0, 8'h00));
        // Start plus size beyond the counter range of the start field must not wrap.
        offer(make_cmd(KIND_FILL,  200, 200, 511, 511, 8'h5A));
        // Outline whose far border lies off the canvas: only the near edges appear.
        offer(make_cmd(KIND_OUTLINE, 250, 250, 511, 511, 8'hC3));
        offer(make_cmd(KIND_READ,  250, 255,   0,   0, 8'h00));
        offer(make_cmd(KIND_READ,  252, 252,   0,   0, 8'h00));
        offer(make_cmd(KIND_READ,  255, 250,   0,   0, 8'h00));
        offer(make_cmd(KIND_FILL,    0,   0,   1, 256, 8'h7F));
        offer(make_cmd(KIND_READ,    0, 255,   0,   0, 8'h00));

        // Rows beyond the canvas clamp; single column; brightest background.
        start_phase(300, 1, 255, 1'b0);
        random_run(ITEMS_PER_PHASE);
        // Single row across the full width; zero background.
        start_phase(1, 256, 0, 1'b0);
        random_run(ITEMS_PER_PHASE);
        // Empty canvas: nothing drawn, every read lies outside.
        start_phase(0, 7, $urandom_range(0, 255), 1'b1);
        random_run(ITEMS_PER_PHASE);
        repeat (3)
        begin
            start_phase($urandom_range(1, 24), $urandom_range(1, 24),
                        $urandom_range(0, 255), 1'b0);
            random_run(ITEMS_PER_PHASE);
        end

        // Drain with a bound, then let the block sit a little before judging.
        cmd_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && rsp_seen != cmds_sent; k++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && rsp_seen == cmds_sent)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
